FILE: hw/rtl/mfqs_pkg.sv
// ----------------------------------------------------------------------------
// mfqs_pkg
// Types and constants shared by the feedback queue scheduler files.
// ----------------------------------------------------------------------------
package mfqs_pkg;

    // scheduler event codes
    typedef enum logic [1:0] {
        ACT_READY = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_BLOCK = 2'd2,
        ACT_EXIT  = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_LEVELS_IN_USE = 2'd0,
        CFG_QUANTUM_1     = 2'd1,
        CFG_QUANTUM_2     = 2'd2,
        CFG_QUANTUM_3     = 2'd3
    } cfg_index_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUANTUM_W   = 16;
    localparam int LEVELS_W    = 3;

    localparam logic [LEVELS_W-1:0]  LEVELS_RESET   = 3'd4;
    localparam logic [QUANTUM_W-1:0] QUANTUM1_RESET = 16'd2;
    localparam logic [QUANTUM_W-1:0] QUANTUM2_RESET = 16'd4;
    localparam logic [QUANTUM_W-1:0] QUANTUM3_RESET = 16'd8;
    localparam logic [QUANTUM_W-1:0] QUANTUM_LEVEL0 = 16'd1;

    typedef struct packed {
        logic [LEVELS_W-1:0]  levels_in_use;
        logic [QUANTUM_W-1:0] quantum_level1;
        logic [QUANTUM_W-1:0] quantum_level2;
        logic [QUANTUM_W-1:0] quantum_level3;
    } sched_cfg_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DATA = 1'b1
    } sched_state_t;

endpackage

FILE: hw/rtl/mfqs_if.sv
// ----------------------------------------------------------------------------
// mfqs interfaces
// Valid/ready channels for scheduler events, dispatch results and config.
// ----------------------------------------------------------------------------
interface mfqs_in_if #(
    parameter int TASK_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [TASK_BITS-1:0] task_id;
    logic [TASK_BITS-1:0] running_task;
    logic                 running_idle;

    modport source (output valid, action, task_id, running_task, running_idle,
                    input ready);
    modport sink (input valid, action, task_id, running_task, running_idle,
                  output ready);
endinterface

interface mfqs_out_if #(
    parameter int TASK_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [TASK_BITS-1:0] next_task;
    logic                 next_idle;
    logic                 queue_overflow;

    modport source (output valid, next_task, next_idle, queue_overflow,
                    input ready);
    modport sink (input valid, next_task, next_idle, queue_overflow,
                  output ready);
endinterface

interface mfqs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mfqs_pkg::CFG_INDEX_W-1:0] index;
    logic [mfqs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/multilevel_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Single-CPU multilevel feedback queue scheduler with RAM-backed level FIFOs.
// ----------------------------------------------------------------------------
// A ready event (action 0) is taken in ST_IDLE and writes the task into the
// level-0 FIFO; it gives no result. Tick, block and exit events pass through
// ST_IDLE, which reads the head entry of the first non-empty level from the
// queue RAM (one read port, registered read data) when a task is taken and
// updates the head and count, then ST_DATA, which loads the result register
// and writes a demoted task back through the write port. The block takes no
// new event in ST_DATA, and holds ST_DATA while a previous result is not yet
// taken. All LEVELS*FIFO_DEPTH queue entries live in a single RAM; only
// entries counted as held are ever read, so it needs no clearing after reset.
module multilevel_feedback_queue_scheduler #(
    parameter int LEVELS     = 4,
    parameter int FIFO_DEPTH = 16,
    parameter int TASK_BITS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    mfqs_in_if.sink    sched_in,
    mfqs_out_if.source sched_out,
    mfqs_cfg_if.sink   cfg
);
    import mfqs_pkg::*;

    localparam int RAM_DEPTH = LEVELS * FIFO_DEPTH;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    sched_cfg_t           cfg_values;
    logic                 ram_rd_en;
    logic [ADDR_W-1:0]    ram_rd_addr;
    logic [TASK_BITS-1:0] ram_rd_data;
    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [TASK_BITS-1:0] ram_wr_data;

    mfqs_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    mfqs_ctrl #(
        .LEVELS     (LEVELS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .TASK_BITS  (TASK_BITS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .sched_in    (sched_in),
        .sched_out   (sched_out),
        .cfg_values  (cfg_values),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    mfqs_ram #(
        .WIDTH  (TASK_BITS),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: hw/rtl/mfqs_ram.sv
// ----------------------------------------------------------------------------
// mfqs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mfqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/mfqs_cfg_regs.sv
// ----------------------------------------------------------------------------
// mfqs_cfg_regs
// Configuration register file: level count and per-level quanta.
// ----------------------------------------------------------------------------
module mfqs_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    mfqs_cfg_if.sink             cfg,
    output mfqs_pkg::sched_cfg_t cfg_values
);
    import mfqs_pkg::*;

    sched_cfg_t cfg_reg;
    sched_cfg_t cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_LEVELS_IN_USE: cfg_next.levels_in_use  = cfg.data[LEVELS_W-1:0];
                CFG_QUANTUM_1:     cfg_next.quantum_level1 = cfg.data;
                CFG_QUANTUM_2:     cfg_next.quantum_level2 = cfg.data;
                CFG_QUANTUM_3:     cfg_next.quantum_level3 = cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.levels_in_use  <= LEVELS_RESET;
            cfg_reg.quantum_level1 <= QUANTUM1_RESET;
            cfg_reg.quantum_level2 <= QUANTUM2_RESET;
            cfg_reg.quantum_level3 <= QUANTUM3_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_values = cfg_reg;

endmodule

FILE: hw/rtl/mfqs_ctrl.sv
// ----------------------------------------------------------------------------
// mfqs_ctrl
// Event sequencer: level search, head/count bookkeeping, quantum countdown,
// queue RAM access and the result register.
// ----------------------------------------------------------------------------
module mfqs_ctrl #(
    parameter int LEVELS     = 4,
    parameter int FIFO_DEPTH = 16,
    parameter int TASK_BITS  = 8,
    parameter int ADDR_W     = (LEVELS * FIFO_DEPTH > 1) ? $clog2(LEVELS * FIFO_DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mfqs_in_if.sink              sched_in,
    mfqs_out_if.source           sched_out,
    input  mfqs_pkg::sched_cfg_t cfg_values,
    output logic                 ram_rd_en,
    output logic [ADDR_W-1:0]    ram_rd_addr,
    input  logic [TASK_BITS-1:0] ram_rd_data,
    output logic                 ram_wr_en,
    output logic [ADDR_W-1:0]    ram_wr_addr,
    output logic [TASK_BITS-1:0] ram_wr_data
);
    import mfqs_pkg::*;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int HEAD_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W  = $clog2(2 * FIFO_DEPTH);

    typedef struct packed {
        logic                 from_ram;
        logic                 do_push;
        logic [LVL_W-1:0]     push_lvl;
        logic [TASK_BITS-1:0] push_task;
        logic [TASK_BITS-1:0] emit_task;
        logic                 emit_idle;
    } event_ctx_t;

    sched_state_t state_reg, state_next;
    event_ctx_t   ctx_reg, ctx_next;

    logic [HEAD_W-1:0]    head_reg [LEVELS];
    logic [HEAD_W-1:0]    head_next [LEVELS];
    logic [CNT_W-1:0]     count_reg [LEVELS];
    logic [CNT_W-1:0]     count_next [LEVELS];
    logic [QUANTUM_W-1:0] ticks_reg, ticks_next;
    logic [LVL_W-1:0]     run_lvl_reg, run_lvl_next;
    logic                 ovf_reg, ovf_next;

    logic                 out_valid_reg, out_valid_next;
    logic [TASK_BITS-1:0] out_task_reg, out_task_next;
    logic                 out_idle_reg, out_idle_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 in_accept;
    action_t              act;
    logic                 found;
    logic [LVL_W-1:0]     w_lvl;
    logic [3:0]           act_lvls;
    logic [3:0]           run_plus;
    logic [3:0]           target4;
    logic [LVL_W-1:0]     target_lvl;
    logic [QUANTUM_W-1:0] w_quantum;
    logic [QUANTUM_W-1:0] ticks_dec;
    logic                 take;
    logic                 push_req;
    logic [LVL_W-1:0]     push_lvl;
    logic [TASK_BITS-1:0] push_task;
    logic                 push_full;
    logic                 drop;
    logic                 load;
    logic [SUM_W-1:0]     slot_sum;
    logic [HEAD_W-1:0]    slot;

    assign in_accept      = sched_in.valid && sched_in.ready;
    assign act            = action_t'(sched_in.action);
    assign sched_in.ready = (state_reg == ST_IDLE);

    // first non-empty level, lowest index wins
    always_comb
    begin
        found = 1'b0;
        w_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                found = 1'b1;
                w_lvl = LVL_W'(l);
            end
        end
    end

    // demotion target, clamped to the active level range
    always_comb
    begin
        act_lvls = {1'b0, cfg_values.levels_in_use};
        if (act_lvls == 4'd0)
        begin
            act_lvls = 4'd1;
        end
        else if (act_lvls > 4'(LEVELS))
        begin
            act_lvls = 4'(LEVELS);
        end
        run_plus   = 4'(run_lvl_reg) + 4'd1;
        target4    = (run_plus < act_lvls) ? run_plus : (act_lvls - 4'd1);
        target_lvl = LVL_W'(target4);
    end

    always_comb
    begin
        case (4'(w_lvl))
            4'd0:    w_quantum = QUANTUM_LEVEL0;
            4'd1:    w_quantum = cfg_values.quantum_level1;
            4'd2:    w_quantum = cfg_values.quantum_level2;
            default: w_quantum = cfg_values.quantum_level3;
        endcase
    end

    assign ticks_dec   = (ticks_reg == '0) ? '0 : (ticks_reg - QUANTUM_W'(1));
    assign ram_rd_addr = ADDR_W'(w_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_reg[w_lvl]);

    always_comb
    begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        ticks_next     = ticks_reg;
        run_lvl_next   = run_lvl_reg;
        out_valid_next = out_valid_reg;
        out_task_next  = out_task_reg;
        out_idle_next  = out_idle_reg;
        take           = 1'b0;
        push_req       = 1'b0;
        push_lvl       = '0;
        push_task      = sched_in.task_id;
        load           = 1'b0;

        if (out_valid_reg && sched_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (act == ACT_READY)
                    begin
                        push_req = 1'b1;
                    end
                    else
                    begin
                        state_next        = ST_DATA;
                        ctx_next.from_ram = 1'b0;
                        ctx_next.do_push  = 1'b0;
                        ctx_next.push_lvl = target_lvl;
                        ctx_next.push_task = sched_in.running_task;
                        ctx_next.emit_task = '0;
                        ctx_next.emit_idle = 1'b1;
                        unique case (act)
                            ACT_TICK:
                            begin
                                if (!sched_in.running_idle)
                                begin
                                    if (ticks_dec == '0 && found)
                                    begin
                                        take             = 1'b1;
                                        ctx_next.do_push = 1'b1;
                                    end
                                    else
                                    begin
                                        // not expired, or nothing waiting at expiry: count down, stay at zero
                                        ticks_next         = ticks_dec;
                                        ctx_next.emit_task = sched_in.running_task;
                                        ctx_next.emit_idle = 1'b0;
                                    end
                                end
                                else
                                begin
                                    take = found;
                                end
                            end
                            ACT_BLOCK:
                            begin
                                take = found;
                                if (!found && !sched_in.running_idle)
                                begin
                                    ctx_next.emit_task = sched_in.running_task;
                                    ctx_next.emit_idle = 1'b0;
                                end
                            end
                            ACT_EXIT:
                            begin
                                take = found;
                            end
                            ACT_READY:
                            begin
                                take = 1'b0;
                            end
                        endcase
                        if (take)
                        begin
                            ctx_next.from_ram  = 1'b1;
                            ctx_next.emit_idle = 1'b0;
                            ticks_next         = w_quantum;
                            run_lvl_next       = w_lvl;
                        end
                    end
                end
            end
            ST_DATA:
            begin
                if (!out_valid_reg || sched_out.ready)
                begin
                    load           = 1'b1;
                    push_req       = ctx_reg.do_push;
                    push_lvl       = ctx_reg.push_lvl;
                    push_task      = ctx_reg.push_task;
                    out_valid_next = 1'b1;
                    out_task_next  = ctx_reg.from_ram ? ram_rd_data : ctx_reg.emit_task;
                    out_idle_next  = ctx_reg.emit_idle;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // tail slot of the push level, counts already reflect any pop
    always_comb
    begin
        slot_sum = SUM_W'(head_reg[push_lvl]) + SUM_W'(count_reg[push_lvl]);
        if (slot_sum >= SUM_W'(FIFO_DEPTH))
        begin
            slot_sum = slot_sum - SUM_W'(FIFO_DEPTH);
        end
        slot = slot_sum[HEAD_W-1:0];
    end

    assign push_full   = (count_reg[push_lvl] == CNT_W'(FIFO_DEPTH));
    assign drop        = push_req && push_full;
    assign ram_wr_en   = push_req && !push_full;
    assign ram_wr_addr = ADDR_W'(push_lvl) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(slot);
    assign ram_wr_data = push_task;
    assign ram_rd_en   = take;

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        out_ovf_next = out_ovf_reg;
        if (take)
        begin
            head_next[w_lvl]  = (head_reg[w_lvl] == HEAD_W'(FIFO_DEPTH - 1)) ?
                                '0 : (head_reg[w_lvl] + HEAD_W'(1));
            count_next[w_lvl] = count_reg[w_lvl] - CNT_W'(1);
        end
        if (ram_wr_en)
        begin
            count_next[push_lvl] = count_reg[push_lvl] + CNT_W'(1);
        end
        if (load)
        begin
            out_ovf_next = ovf_reg || drop;
            ovf_next     = 1'b0;
        end
        else if (drop)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ticks_reg     <= '0;
            run_lvl_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ticks_reg     <= ticks_next;
            run_lvl_reg   <= run_lvl_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg      <= ctx_next;
        out_task_reg <= out_task_next;
        out_idle_reg <= out_idle_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign sched_out.valid          = out_valid_reg;
    assign sched_out.next_task      = out_task_reg;
    assign sched_out.next_idle      = out_idle_reg;
    assign sched_out.queue_overflow = out_ovf_reg;

endmodule

FILE: hw/rtl/mfqs_checker.sv
// ----------------------------------------------------------------------------
// mfqs_checker
// Port-level assertions for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mfqs_checker #(
    parameter int TASK_BITS = 8
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [1:0]           in_action,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [TASK_BITS-1:0] out_next_task,
    input logic                 out_next_idle,
    input logic                 out_queue_overflow
);
    import mfqs_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_next_task)
            && $stable(out_next_idle) && $stable(out_queue_overflow))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_next_idle |-> out_next_task == '0)
        else $error("idle result carries a task id");

    // events with a result move the block to ST_DATA, where it takes no new event
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action != ACT_READY |=> !in_ready)
        else $error("item accepted during result cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a pending event");

endmodule

bind multilevel_feedback_queue_scheduler mfqs_checker #(
    .TASK_BITS (TASK_BITS)
) u_mfqs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (sched_in.valid),
    .in_ready           (sched_in.ready),
    .in_action          (sched_in.action),
    .out_valid          (sched_out.valid),
    .out_ready          (sched_out.ready),
    .out_next_task      (sched_out.next_task),
    .out_next_idle      (sched_out.next_idle),
    .out_queue_overflow (sched_out.queue_overflow)
);

FILE: test/mfqs_dispatch_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfqs_dispatch_check
// Watches the event, dispatch and config channels of the feedback queue
// scheduler, keeps its own copy of the level queues and compares every
// dispatch result with the predicted one.
// ----------------------------------------------------------------------------
module mfqs_dispatch_check #(
    parameter int LEVELS     = 4,
    parameter int FIFO_DEPTH = 16,
    parameter int TASK_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    mfqs_in_if          sched_in,
    mfqs_out_if         sched_out,
    mfqs_cfg_if         cfg,
    output int unsigned error_count,
    output int unsigned pending_results
);
    import mfqs_pkg::*;

    typedef struct packed {
        logic [TASK_BITS-1:0] next_id;
        logic                 idle;
        logic                 overflow;
    } dispatch_t;

    logic [TASK_BITS-1:0] level_mem [LEVELS][FIFO_DEPTH];
    int unsigned          level_head [LEVELS];
    int unsigned          level_fill [LEVELS];
    logic [QUANTUM_W-1:0] ticks_left;
    int unsigned          run_level;
    logic                 drop_seen;

    logic [LEVELS_W-1:0]  set_levels;
    logic [QUANTUM_W-1:0] set_q1;
    logic [QUANTUM_W-1:0] set_q2;
    logic [QUANTUM_W-1:0] set_q3;

    dispatch_t            expected_dispatches [$];
    dispatch_t            want;
    int unsigned          errors = 0;

    assign error_count = errors;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int unsigned active_levels();
        if (set_levels == '0)
            return 1;
        if (int'(set_levels) > LEVELS)
            return LEVELS;
        return int'(set_levels);
    endfunction

    function automatic logic [QUANTUM_W-1:0] level_quantum(input int unsigned lvl);
        case (lvl)
            0: return QUANTUM_LEVEL0;
            1: return set_q1;
            2: return set_q2;
            default: return set_q3;
        endcase
    endfunction

    function automatic void push_task(input int unsigned lvl, input logic [TASK_BITS-1:0] id);
        int unsigned l;
        int unsigned slot;
        l = (lvl >= LEVELS) ? LEVELS - 1 : lvl;
        if (level_fill[l] >= FIFO_DEPTH)
        begin
            drop_seen = 1'b1;
        end
        else
        begin
            slot = (level_head[l] + level_fill[l]) % FIFO_DEPTH;
            level_mem[l][slot] = id;
            level_fill[l]++;
        end
    endfunction

    function automatic int first_waiting_level();
        for (int l = 0; l < LEVELS; l++)
            if (level_fill[l] != 0)
                return l;
        return -1;
    endfunction

    // pop the head and load that level's quantum
    function automatic logic [TASK_BITS-1:0] take_head(input int unsigned lvl);
        logic [TASK_BITS-1:0] id;
        id = level_mem[lvl][level_head[lvl]];
        level_head[lvl] = (level_head[lvl] + 1) % FIFO_DEPTH;
        level_fill[lvl]--;
        ticks_left = level_quantum(lvl);
        run_level = lvl;
        return id;
    endfunction

    function automatic void post_dispatch(input logic [TASK_BITS-1:0] id, input logic idle);
        dispatch_t d;
        d.next_id = idle ? '0 : id;
        d.idle = idle;
        d.overflow = drop_seen;
        drop_seen = 1'b0;
        expected_dispatches.insert(expected_dispatches.size(), d);
    endfunction

    task automatic predict_dispatch(input action_t act, input logic [TASK_BITS-1:0] id,
                                    input logic [TASK_BITS-1:0] cur, input logic cur_idle);
        int                   w;
        int unsigned          lim;
        int unsigned          target;
        logic [TASK_BITS-1:0] nxt;
        w = first_waiting_level();
        case (act)
            ACT_READY:
            begin
                push_task(0, id);
            end
            ACT_BLOCK, ACT_EXIT:
            begin
                if (w >= 0)
                    post_dispatch(take_head(w), 1'b0);
                else if (act == ACT_EXIT)
                    post_dispatch('0, 1'b1);
                else
                    post_dispatch(cur, cur_idle);
            end
            default:
            begin
                if (cur_idle)
                begin
                    if (w >= 0)
                        post_dispatch(take_head(w), 1'b0);
                    else
                        post_dispatch('0, 1'b1);
                end
                else
                begin
                    if (ticks_left != '0)
                        ticks_left--;
                    if (ticks_left == '0 && w >= 0)
                    begin
                        // target from the old level, head removed before the requeue
                        lim = active_levels();
                        target = (run_level + 1 < lim) ? run_level + 1 : lim - 1;
                        nxt = take_head(w);
                        push_task(target, cur);
                        post_dispatch(nxt, 1'b0);
                    end
                    else
                    begin
                        post_dispatch(cur, 1'b0);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                level_head[l] = 0;
                level_fill[l] = 0;
            end
            ticks_left = '0;
            run_level = 0;
            drop_seen = 1'b0;
            set_levels = LEVELS_RESET;
            set_q1 = QUANTUM1_RESET;
            set_q2 = QUANTUM2_RESET;
            set_q3 = QUANTUM3_RESET;
            expected_dispatches.delete();
            pending_results <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_LEVELS_IN_USE: set_levels = cfg.data[LEVELS_W-1:0];
                    CFG_QUANTUM_1:     set_q1 = cfg.data;
                    CFG_QUANTUM_2:     set_q2 = cfg.data;
                    CFG_QUANTUM_3:     set_q3 = cfg.data;
                    default:           ;
                endcase
            end

            if (sched_in.valid && sched_in.ready)
                predict_dispatch(action_t'(sched_in.action), sched_in.task_id,
                                 sched_in.running_task, sched_in.running_idle);

            if (sched_out.valid && sched_out.ready)
            begin
                if (expected_dispatches.size() == 0)
                begin
                    report_error($sformatf("dispatch item with none outstanding: task %0h",
                                           sched_out.next_task));
                end
                else
                begin
                    want = expected_dispatches.pop_front();
                    if (sched_out.next_task !== want.next_id)
                        report_error($sformatf("next_task got %0h expected %0h",
                                               sched_out.next_task, want.next_id));
                    if (sched_out.next_idle !== want.idle)
                        report_error($sformatf("next_idle got %0b expected %0b",
                                               sched_out.next_idle, want.idle));
                    if (sched_out.queue_overflow !== want.overflow)
                        report_error($sformatf("queue_overflow got %0b expected %0b",
                                               sched_out.queue_overflow, want.overflow));
                end
            end

            pending_results <= expected_dispatches.size();
        end
    end

endmodule

FILE: test/multilevel_feedback_queue_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_test
// Drives scheduler events and register settings into the feedback queue
// scheduler with random gaps and back-pressure; a separate checker predicts
// and compares every dispatch, and this module gives the verdict.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_test;
    import mfqs_pkg::*;

    localparam int LEVELS           = 4;
    localparam int FIFO_DEPTH       = 16;
    localparam int TASK_BITS        = 8;
    localparam int PHASES           = 9;
    localparam int RANDOM_PER_PHASE = 45;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_AT          = 150;
    localparam int HOLD_CYCLES      = 300;
    localparam int QUIET_LIMIT      = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mfqs_in_if  #(.TASK_BITS(TASK_BITS)) sched_in ();
    mfqs_out_if #(.TASK_BITS(TASK_BITS)) sched_out ();
    mfqs_cfg_if cfg ();

    int unsigned          error_count;
    int unsigned          pending_results;
    int unsigned          results_taken = 0;
    int unsigned          quiet_cycles = 0;
    bit                   no_idling = 1'b0;
    logic [TASK_BITS-1:0] cpu_task = '0;
    logic                 cpu_idle = 1'b1;

    multilevel_feedback_queue_scheduler #(
        .LEVELS     (LEVELS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .TASK_BITS  (TASK_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sched_in  (sched_in),
        .sched_out (sched_out),
        .cfg       (cfg)
    );

    mfqs_dispatch_check #(
        .LEVELS     (LEVELS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .TASK_BITS  (TASK_BITS)
    ) dispatch_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .sched_in        (sched_in),
        .sched_out       (sched_out),
        .cfg             (cfg),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        return no_idling ? 0 : $urandom_range(0, 10);
    endfunction

    // valid stays high between back-to-back items
    task automatic send_event(input action_t act, input logic [TASK_BITS-1:0] id,
                              input logic [TASK_BITS-1:0] cur, input logic cur_idle);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            sched_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sched_in.valid <= 1'b1;
        sched_in.action <= act;
        sched_in.task_id <= id;
        sched_in.running_task <= cur;
        sched_in.running_idle <= cur_idle;
        @(posedge clk);
        while (!sched_in.ready) @(posedge clk);
    endtask

    task automatic random_event();
        int unsigned          pick;
        action_t              act;
        logic [TASK_BITS-1:0] cur;
        logic                 cur_idle;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            act = ACT_READY;
        else if (pick < 75)
            act = ACT_TICK;
        else if (pick < 87)
            act = ACT_BLOCK;
        else
            act = ACT_EXIT;
        // mostly report the task the scheduler last picked
        if ($urandom_range(0, 4) != 0)
        begin
            cur = cpu_task;
            cur_idle = cpu_idle;
        end
        else
        begin
            cur = TASK_BITS'($urandom_range(0, (1 << TASK_BITS) - 1));
            cur_idle = 1'($urandom_range(0, 1));
        end
        send_event(act, TASK_BITS'($urandom_range(0, (1 << TASK_BITS) - 1)), cur, cur_idle);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [LEVELS_W-1:0] lv, input logic [QUANTUM_W-1:0] q1,
                                  input logic [QUANTUM_W-1:0] q2, input logic [QUANTUM_W-1:0] q3);
        logic [CFG_DATA_W-1:0] word;
        // upper bits of the levels word are don't-care, toggle them anyway
        word = CFG_DATA_W'($urandom());
        word[LEVELS_W-1:0] = lv;
        cfg_put(CFG_LEVELS_IN_USE, word);
        cfg_put(CFG_QUANTUM_1, q1);
        cfg_put(CFG_QUANTUM_2, q2);
        cfg_put(CFG_QUANTUM_3, q3);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned          k;
        int unsigned          phase;
        logic [LEVELS_W-1:0]  lv;
        logic [QUANTUM_W-1:0] q1;
        logic [QUANTUM_W-1:0] q2;
        logic [QUANTUM_W-1:0] q3;
        sched_in.valid = 1'b0;
        sched_in.action = ACT_READY;
        sched_in.task_id = '0;
        sched_in.running_task = '0;
        sched_in.running_idle = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_LEVELS_IN_USE;
        cfg.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset settings
        send_event(ACT_EXIT, 8'h00, 8'hFF, 1'b0);   // exit with nothing waiting
        send_event(ACT_BLOCK, 8'hFF, 8'hA5, 1'b0);  // block keeps the running task
        send_event(ACT_BLOCK, 8'h00, 8'h3C, 1'b1);  // block while idle
        send_event(ACT_TICK, 8'hFF, 8'h00, 1'b1);   // idle tick, nothing waiting
        send_event(ACT_TICK, 8'h00, 8'h81, 1'b0);   // expiry with nothing waiting
        send_event(ACT_TICK, 8'h00, 8'h81, 1'b0);   // count held at zero
        send_event(ACT_READY, 8'hFF, 8'h00, 1'b0);
        send_event(ACT_READY, 8'h00, 8'h00, 1'b0);
        send_event(ACT_READY, 8'h5A, 8'h00, 1'b0);
        send_event(ACT_TICK, 8'h00, 8'h00, 1'b1);   // idle cpu takes the head
        send_event(ACT_TICK, 8'h00, 8'hFF, 1'b0);   // level-0 expiry, demote
        send_event(ACT_TICK, 8'h00, 8'h00, 1'b0);
        send_event(ACT_TICK, 8'h00, 8'h5A, 1'b0);
        send_event(ACT_TICK, 8'h00, 8'hFF, 1'b0);
        send_event(ACT_TICK, 8'h00, 8'hFF, 1'b0);
        send_event(ACT_BLOCK, 8'h00, 8'h00, 1'b0);
        send_event(ACT_EXIT, 8'h00, 8'h5A, 1'b0);
        // overrun level 0, then report the drop
        for (k = 0; k < FIFO_DEPTH + 1; k++)
            send_event(ACT_READY, TASK_BITS'($urandom_range(0, (1 << TASK_BITS) - 1)),
                       8'h00, 1'b0);
        send_event(ACT_EXIT, 8'h00, 8'h00, 1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                case (phase)
                    1: begin lv = 3'd0; q1 = 16'd0; q2 = 16'd0; q3 = 16'd0; end
                    2: begin lv = 3'd1; q1 = 16'd1; q2 = 16'd1; q3 = 16'd1; end
                    3: begin lv = 3'd7; q1 = 16'hFFFF; q2 = 16'hFFFF; q3 = 16'hFFFF; end
                    4: begin lv = 3'd2; q1 = 16'd3; q2 = 16'd0; q3 = 16'hFFFF; end
                    5:
                    begin
                        lv = 3'd3;
                        q1 = QUANTUM_W'($urandom_range(1, 6));
                        q2 = QUANTUM_W'($urandom_range(1, 6));
                        q3 = QUANTUM_W'($urandom_range(1, 6));
                    end
                    6:
                    begin
                        lv = 3'd5;
                        q1 = QUANTUM_W'($urandom_range(0, 4));
                        q2 = QUANTUM_W'($urandom_range(0, 4));
                        q3 = QUANTUM_W'($urandom_range(0, 4));
                    end
                    7:
                    begin
                        lv = 3'd4;
                        q1 = QUANTUM_W'($urandom_range(1, 8));
                        q2 = QUANTUM_W'($urandom_range(1, 8));
                        q3 = QUANTUM_W'($urandom_range(1, 8));
                    end
                    default: begin lv = 3'd6; q1 = 16'd2; q2 = 16'hFFFF; q3 = 16'd1; end
                endcase
                apply_settings(lv, q1, q2, q3);
            end
            no_idling <= (phase == 2 || phase == 6);
            for (k = 0; k < RANDOM_PER_PHASE; k++)
                random_event();
            sched_in.valid <= 1'b0;
            wait_drained();
        end

        if (error_count == 0 && pending_results == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : receiver
        int unsigned gap;
        sched_out.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            sched_out.ready <= 1'b1;
            @(posedge clk);
            while (!sched_out.valid) @(posedge clk);
            results_taken++;
            cpu_task <= sched_out.next_task;
            cpu_idle <= sched_out.next_idle;
            if (results_taken == HOLD_AT)
            begin
                // long hold-off so the event side backs up
                sched_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = draw_gap();
                if (gap != 0)
                begin
                    sched_out.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sched_in.valid && sched_in.ready) || (sched_out.valid && sched_out.ready) ||
                (cfg.valid && cfg.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

FILE: sim.f
hw/rtl/mfqs_pkg.sv
hw/rtl/mfqs_if.sv
hw/rtl/mfqs_ram.sv
hw/rtl/mfqs_cfg_regs.sv
hw/rtl/mfqs_ctrl.sv
hw/rtl/multilevel_feedback_queue_scheduler.sv
hw/rtl/mfqs_checker.sv
test/mfqs_dispatch_check.sv
test/multilevel_feedback_queue_scheduler_test.sv
